@@ sv/ptst_pkg.sv @@
// ptst_pkg: shared types and constants of the periodic timer slot table
// used by periodic_timer_slot_table and ptst_checker
`timescale 1ns / 1ps

package ptst_pkg;

  // most firings that one tick reports
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_REGISTER   = 2'd1,
    CMD_UNREGISTER = 2'd2,
    CMD_CLEAR      = 2'd3
  } ptst_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_PER  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_USED  = 2'd3
  } ptst_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } ptst_state_e;

  typedef struct packed {
    ptst_cmd_e   command;
    logic [15:0] period;
    logic [3:0]  slot_id;
  } ptst_in_t;

  typedef struct packed {
    logic         fired;
    logic [3:0]   slot_number;
    ptst_status_e status;
    logic         last;
  } ptst_out_t;

endpackage

@@ sv/ptst_cell.sv @@
// ptst_cell: one slot of the rotating timer ring (live flag, period, count)
// takes its neighbour's slot on every shift; no package dependencies
`timescale 1ns / 1ps

module ptst_cell #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic                   live_i,
  input  logic [PERIOD_BITS-1:0] period_i,
  input  logic [PERIOD_BITS-1:0] count_i,
  output logic                   live_o,
  output logic [PERIOD_BITS-1:0] period_o,
  output logic [PERIOD_BITS-1:0] count_o
);

  logic                   live_q;
  logic [PERIOD_BITS-1:0] period_q;
  logic [PERIOD_BITS-1:0] count_q;

  // live flag is control state and is cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= live_i;
    end
  end

  // period and count only matter while live
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      period_q <= period_i;
      count_q  <= count_i;
    end
  end

  assign live_o   = live_q;
  assign period_o = period_q;
  assign count_o  = count_q;

endmodule

@@ sv/periodic_timer_slot_table.sv @@
// periodic_timer_slot_table: top level, ring of ptst_cell slots and a sequencer
// depends on ptst_pkg and ptst_cell
`timescale 1ns / 1ps

// Usage
//   in_valid_i / in_stall_o / in_data_i carry one command word (tick, register,
//   unregister, clear). out_valid_o / out_stall_i / out_data_o carry result words.
//   The slots sit in a ring of SLOTS cells that rotates one place per cycle
//   while a command runs and the output is not stalled; the cell at the head
//   is updated by the command as it passes, so every command takes one full
//   rotation of the ring after it is accepted, and the flush state then loads
//   the final word into the output register.
//   in_stall_o stays high from acceptance until the final word is in the
//   output register. A tick gives one word per firing slot, up to MAX_RESULTS, in slot order
//   (none if nothing fires); every other command gives exactly one word.
//   The final word of a command carries last=1.
//   While out_stall_i holds a waiting word, the ring stops and resumes
//   when the output register is free, so nothing is lost.
//   Reset empties the table (all slots free) and drops any word in flight.

module periodic_timer_slot_table
  import ptst_pkg::*;
#(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ptst_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ptst_out_t out_data_o
);

  localparam int unsigned SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // ring of cells
  logic                   live   [SLOTS];
  logic [PERIOD_BITS-1:0] period [SLOTS];
  logic [PERIOD_BITS-1:0] count  [SLOTS];

  logic                   head_live;
  logic [PERIOD_BITS-1:0] head_period;
  logic [PERIOD_BITS-1:0] head_count;
  logic                   shift;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      ptst_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .live_i  (head_live),
        .period_i(head_period),
        .count_i (head_count),
        .live_o  (live[i]),
        .period_o(period[i]),
        .count_o (count[i])
      );
    end else begin : g_body
      ptst_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .live_i  (live[i+1]),
        .period_i(period[i+1]),
        .count_i (count[i+1]),
        .live_o  (live[i]),
        .period_o(period[i]),
        .count_o (count[i])
      );
    end
  end

  // sequencer registers
  ptst_state_e             state_q, state_d;
  ptst_in_t                cmd_q, cmd_d;
  logic [SB-1:0]           step_q, step_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [3:0]              pend_slot_q, pend_slot_d;
  logic [RES_CNT_BITS-1:0] rep_cnt_q, rep_cnt_d;
  logic                    found_q, found_d;
  logic [3:0]              found_slot_q, found_slot_d;
  logic                    hit_q, hit_d;
  logic                    out_valid_q, out_valid_d;
  ptst_out_t               out_q, out_d;

  logic                   adv;
  logic [PERIOD_BITS-1:0] per_m;
  logic [47:0]            per_wide;
  logic [7:0]             step_w;
  logic                   id_match;

  assign adv      = !out_valid_q || !out_stall_i;
  assign per_wide = 48'(cmd_q.period);
  assign per_m    = per_wide[PERIOD_BITS-1:0];
  assign step_w   = 8'(step_q);
  assign id_match = (32'(cmd_q.slot_id) == 32'(step_q));

  // next state, head cell update and result words
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    step_d       = step_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    rep_cnt_d    = rep_cnt_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    hit_d        = hit_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    shift        = 1'b0;
    head_live    = live[0];
    head_period  = period[0];
    head_count   = count[0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = in_data_i;
          step_d       = '0;
          pend_valid_d = 1'b0;
          rep_cnt_d    = '0;
          found_d      = 1'b0;
          hit_d        = 1'b0;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          shift = 1'b1;
          case (cmd_q.command)
            CMD_TICK: begin
              if (live[0]) begin
                if (count[0] == period[0]) begin
                  head_count = '0;
                  if (32'(rep_cnt_q) < MAX_RESULTS) begin
                    if (pend_valid_q) begin
                      out_valid_d       = 1'b1;
                      out_d.fired       = 1'b1;
                      out_d.slot_number = pend_slot_q;
                      out_d.status      = STAT_OK;
                      out_d.last        = 1'b0;
                    end
                    pend_valid_d = 1'b1;
                    pend_slot_d  = step_w[3:0];
                    rep_cnt_d    = rep_cnt_q + RES_CNT_BITS'(1);
                  end
                end else begin
                  head_count = count[0] + PERIOD_BITS'(1);
                end
              end
            end
            CMD_REGISTER: begin
              if (per_m != '0 && !found_q && !live[0]) begin
                head_live    = 1'b1;
                head_period  = per_m;
                head_count   = '0;
                found_d      = 1'b1;
                found_slot_d = step_w[3:0];
              end
            end
            CMD_UNREGISTER: begin
              if (id_match && live[0]) begin
                head_live = 1'b0;
                hit_d     = 1'b1;
              end
            end
            CMD_CLEAR: begin
              head_live = 1'b0;
            end
            default: begin
              head_live = live[0];
            end
          endcase
          step_d = step_q + SB'(1);
          if (step_q == SB'(SLOTS - 1)) begin
            step_d  = '0;
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_d           = ST_IDLE;
          out_d.fired       = 1'b0;
          out_d.slot_number = '0;
          out_d.status      = STAT_OK;
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          case (cmd_q.command)
            CMD_TICK: begin
              out_valid_d       = pend_valid_q;
              out_d.fired       = 1'b1;
              out_d.slot_number = pend_slot_q;
            end
            CMD_REGISTER: begin
              if (per_m == '0) begin
                out_d.status = STAT_ZERO_PER;
              end else if (!found_q) begin
                out_d.status = STAT_FULL;
              end else begin
                out_d.slot_number = found_slot_q;
              end
            end
            CMD_UNREGISTER: begin
              out_d.slot_number = cmd_q.slot_id;
              if (!hit_q) begin
                out_d.status = STAT_NOT_USED;
              end
            end
            default: begin
              out_d.slot_number = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
      found_q      <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
      found_q      <= found_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pend_slot_q  <= pend_slot_d;
    found_slot_q <= found_slot_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/ptst_checker.sv @@
// ptst_checker: port-level assertions for periodic_timer_slot_table
// depends on ptst_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module ptst_checker
  import ptst_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ptst_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ptst_out_t out_data_o
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  // an accepted command blocks the next one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while previous one is still running");

  // firing words always report ok
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.status == STAT_OK)
    else $error("firing word with non-ok status");

  // only ticks give more than one word, so a non-final word is a firing
  a_multi_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.fired)
    else $error("non-final word that is not a firing");

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (.*);
